@@ rtl/core/bcmp_pkg.sv @@
// ----------------------------------------------------------------------------
// bcmp_pkg
// Shared types and constants for the barometer compensation pipeline.
// ----------------------------------------------------------------------------
package bcmp_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_C = 2'd2;
  localparam int CFG_DATA_W = 64;
  localparam int CAL_C_W    = 32;

  // Divider geometry: one quotient bit per stage
  localparam int DIV_W = 33;
  localparam int TAG_W = 37;
  typedef logic [DIV_W-1:0] div_word_t;

  // Compensation constants
  localparam logic signed [15:0] B6_OFS     = 16'sd4000;
  localparam logic        [31:0] X3_OFS     = 32'd32768;
  localparam logic        [15:0] B7_SCALE   = 16'd50000;
  localparam logic        [11:0] P_SQ_COEF  = 12'd3038;
  localparam logic signed [13:0] P_LIN_COEF = -14'sd7357;
  localparam logic signed [12:0] P_OFS      = 13'sd3791;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [15:0] raw_pressure;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] temperature_decicelsius;
    logic        [19:0] pressure_pa;
    logic               divide_error;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic        [15:0] ac4;
    logic        [15:0] ac5;
    logic        [15:0] ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
  } cal_t;

  // Side band through the temperature divider
  typedef struct packed {
    logic signed [18:0] x1;
    logic        [15:0] up;
    logic               qneg;
    logic               err;
  } ttag_t;

  // Side band through the pressure divider
  typedef struct packed {
    logic        [18:0] pad;
    logic signed [15:0] t;
    logic               halve;
    logic               err;
  } ptag_t;

  typedef struct packed {
    logic             valid;
    div_word_t        dividend;
    div_word_t        divisor;
    logic [TAG_W-1:0] tag;
  } div_req_t;

  typedef struct packed {
    logic             valid;
    div_word_t        quotient;
    logic [TAG_W-1:0] tag;
  } div_rsp_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_t;

endpackage

@@ rtl/core/barometer_compensation.sv @@
// ----------------------------------------------------------------------------
// barometer_compensation
// Pipelined temperature and pressure compensation from factory calibration.
// ----------------------------------------------------------------------------
//  port group | direction | handshake            | word
//  in_        | input     | in_valid / in_ready  | raw temperature, raw pressure
//  out_       | output    | out_valid / out_ready| temperature, pressure, error
//  cfg_       | input     | cfg_we               | calibration word at cfg_index
//
// Takes one word per cycle while in_ready is high. The path has 78 register
// stages: 2 temperature stages, a 33-stage divider, 6 coefficient stages, a
// second 33-stage divider, 3 polynomial stages and the output register. The
// two one-bit-per-stage dividers set the depth.
// Reset (rst_n low, synchronous) clears all valid bits and the calibration.
// A held output word parks the next word in a skid register; only when that
// is full does the pipeline freeze and in_ready drop, so nothing is lost.
// ----------------------------------------------------------------------------
module barometer_compensation (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bcmp_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bcmp_pkg::out_word_t                 out_data,
  input  logic                                cfg_we,
  input  logic [bcmp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcmp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [bcmp_pkg::CFG_DATA_W-1:0] cal_a_r, cal_b_r;
  logic [bcmp_pkg::CAL_C_W-1:0]    cal_c_r;
  bcmp_pkg::cal_t                  cal;

  logic                adv;
  bcmp_pkg::div_req_t  treq, preq;
  bcmp_pkg::div_rsp_t  trsp, prsp;
  bcmp_pkg::res_t      res;

  logic                out_valid_r, skid_valid_r;
  bcmp_pkg::out_word_t out_word_r, skid_word_r;

  // Calibration words: write on cfg_we, drop unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bcmp_pkg::CFG_CAL_A: cal_a_r <= cfg_data;
        bcmp_pkg::CFG_CAL_B: cal_b_r <= cfg_data;
        bcmp_pkg::CFG_CAL_C: cal_c_r <= cfg_data[bcmp_pkg::CAL_C_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack coefficients, first named one in the top bits
  always_comb begin
    cal.ac1 = cal_a_r[63:48];
    cal.ac2 = cal_a_r[47:32];
    cal.ac3 = cal_a_r[31:16];
    cal.ac4 = cal_a_r[15:0];
    cal.ac5 = cal_b_r[63:48];
    cal.ac6 = cal_b_r[47:32];
    cal.b1  = cal_b_r[31:16];
    cal.b2  = cal_b_r[15:0];
    cal.mc  = cal_c_r[31:16];
    cal.md  = cal_c_r[15:0];
  end

  // Advance the whole pipeline unless the skid register is occupied
  assign adv      = ~skid_valid_r;
  assign in_ready = adv;

  bcmp_tfront u_tfront (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_word  (in_data),
    .cal      (cal),
    .req      (treq)
  );

  // X2 = MC * 2048 / (X1 + MD)
  bcmp_div u_tdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .req   (treq),
    .rsp   (trsp)
  );

  bcmp_pcoef u_pcoef (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .rsp   (trsp),
    .cal   (cal),
    .req   (preq)
  );

  // P = B7 * 2 / B4 or B7 / B4 * 2
  bcmp_div u_pdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .req   (preq),
    .rsp   (prsp)
  );

  bcmp_pfinal u_pfinal (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .rsp   (prsp),
    .res   (res)
  );

  // Output register plus skid: hold a stalled word, park the next one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_ready) begin
      if (adv && res.valid) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_ready) begin
      if (adv && res.valid) begin
        skid_word_r <= res.word;
      end
    end else if (skid_valid_r) begin
      out_word_r <= skid_word_r;
    end else begin
      out_word_r <= res.word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // Skid holds a word only behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid occupied with empty output register");

  // Skid only fills when the output was stalled
  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid filled without an output stall");

  // A divide error forces zero results
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.divide_error) |->
      (out_word_r.temperature_decicelsius == '0 && out_word_r.pressure_pa == '0))
    else $error("nonzero result with divide error");

endmodule

@@ rtl/core/bcmp_div.sv @@
// ----------------------------------------------------------------------------
// bcmp_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bcmp_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  bcmp_pkg::div_req_t  req,
  output bcmp_pkg::div_rsp_t  rsp
);

  logic [bcmp_pkg::DIV_W-1:0] rem_r [bcmp_pkg::DIV_W];
  logic [bcmp_pkg::DIV_W-1:0] num_r [bcmp_pkg::DIV_W];
  logic [bcmp_pkg::DIV_W-1:0] dvs_r [bcmp_pkg::DIV_W];
  logic [bcmp_pkg::TAG_W-1:0] tag_r [bcmp_pkg::DIV_W];
  logic                       v_r   [bcmp_pkg::DIV_W];

  for (genvar i = 0; i < bcmp_pkg::DIV_W; i++) begin : g_stage
    logic [bcmp_pkg::DIV_W-1:0] rem_in;
    logic [bcmp_pkg::DIV_W-1:0] num_in;
    logic [bcmp_pkg::DIV_W-1:0] dvs_in;
    logic [bcmp_pkg::TAG_W-1:0] tag_in;
    logic                       v_in;
    logic [bcmp_pkg::DIV_W:0]   shf;
    logic [bcmp_pkg::DIV_W:0]   dif;
    logic                       ge;

    if (i == 0) begin : g_head
      assign rem_in = '0;
      assign num_in = req.dividend;
      assign dvs_in = req.divisor;
      assign tag_in = req.tag;
      assign v_in   = req.valid;
    end else begin : g_body
      assign rem_in = rem_r[i-1];
      assign num_in = num_r[i-1];
      assign dvs_in = dvs_r[i-1];
      assign tag_in = tag_r[i-1];
      assign v_in   = v_r[i-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign shf = {rem_in, num_in[bcmp_pkg::DIV_W-1]};
    assign dif = shf - {1'b0, dvs_in};
    assign ge  = ~dif[bcmp_pkg::DIV_W];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i] <= ge ? dif[bcmp_pkg::DIV_W-1:0] : shf[bcmp_pkg::DIV_W-1:0];
        num_r[i] <= {num_in[bcmp_pkg::DIV_W-2:0], ge};
        dvs_r[i] <= dvs_in;
        tag_r[i] <= tag_in;
      end
    end
  end

  assign rsp.valid    = v_r[bcmp_pkg::DIV_W-1];
  assign rsp.quotient = num_r[bcmp_pkg::DIV_W-1];
  assign rsp.tag      = tag_r[bcmp_pkg::DIV_W-1];

endmodule

@@ rtl/core/bcmp_tfront.sv @@
// ----------------------------------------------------------------------------
// bcmp_tfront
// Temperature front end: X1 and the operands of the first division.
// ----------------------------------------------------------------------------
module bcmp_tfront (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  bcmp_pkg::in_word_t in_word,
  input  bcmp_pkg::cal_t     cal,
  output bcmp_pkg::div_req_t req
);

  logic               v1_r;
  logic signed [18:0] x1_r, x1_nxt;
  logic        [15:0] up_r;
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic signed [19:0] den;
  logic signed [26:0] num;
  logic        [26:0] nmag;
  logic        [19:0] dmag;
  bcmp_pkg::ttag_t    tag;
  bcmp_pkg::div_req_t req_r, req_nxt;

  // stage 1: X1 = (UT - AC6) * AC5 >> 15
  always_comb begin
    diff   = $signed({1'b0, in_word.raw_temperature}) - $signed({1'b0, cal.ac6});
    prod   = diff * $signed({1'b0, cal.ac5});
    x1_nxt = prod[33:15];
  end

  // stage 2: sign-magnitude operands for MC * 2048 / (X1 + MD)
  always_comb begin
    den  = x1_r + cal.md;
    num  = {cal.mc, 11'b0};
    nmag = cal.mc[15] ? 27'(-num) : 27'(num);
    dmag = den[19] ? 20'(-den) : 20'(den);
    tag.x1   = x1_r;
    tag.up   = up_r;
    tag.qneg = cal.mc[15] ^ den[19];
    tag.err  = (den == 20'sd0);
    req_nxt.valid    = v1_r;
    req_nxt.dividend = bcmp_pkg::div_word_t'(nmag);
    req_nxt.divisor  = bcmp_pkg::div_word_t'(dmag);
    req_nxt.tag      = tag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      req_r.valid <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      req_r.valid <= req_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r           <= x1_nxt;
      up_r           <= in_word.raw_pressure;
      req_r.dividend <= req_nxt.dividend;
      req_r.divisor  <= req_nxt.divisor;
      req_r.tag      <= req_nxt.tag;
    end
  end

  assign req = req_r;

endmodule

@@ rtl/core/bcmp_pcoef.sv @@
// ----------------------------------------------------------------------------
// bcmp_pcoef
// Temperature result, B3/B4/B7 and the operands of the pressure division.
// ----------------------------------------------------------------------------
module bcmp_pcoef (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  bcmp_pkg::div_rsp_t rsp,
  input  bcmp_pkg::cal_t     cal,
  output bcmp_pkg::div_req_t req
);

  // stage valids A..E
  logic [4:0] v_r;

  // stage A
  bcmp_pkg::ttag_t    tt;
  logic signed [27:0] x2;
  logic signed [28:0] b5;
  logic signed [29:0] tsum;
  logic signed [25:0] tq;
  logic signed [15:0] tsat;
  logic signed [29:0] b6_nxt;
  logic signed [29:0] b6a_r;
  logic signed [15:0] ta_r;
  logic        [15:0] upa_r;
  logic               erra_r;

  // stage B
  logic signed [59:0] sq_full;
  logic        [54:0] sqb_r;
  logic signed [45:0] m2b_r, m3b_r, m2_nxt, m3_nxt;
  logic signed [15:0] tb_r;
  logic        [15:0] upb_r;
  logic               errb_r;

  // stage C
  logic        [42:0] sq12;
  logic signed [71:0] pa_nxt, pac_r;
  logic signed [59:0] pb_nxt, pbc_r;
  logic signed [45:0] m2c_r, m3c_r;
  logic signed [15:0] tc_r;
  logic        [15:0] upc_r;
  logic               errc_r;

  // stage D
  logic signed [48:0] x1a;
  logic signed [34:0] x2a;
  logic signed [49:0] x3;
  logic signed [50:0] b3s;
  logic signed [32:0] x1b;
  logic signed [43:0] x2b;
  logic signed [44:0] s2;
  logic        [31:0] ulo_nxt, uld_r, b3d_r;
  logic signed [15:0] td_r;
  logic        [15:0] upd_r;
  logic               errd_r;

  // stage E
  logic        [47:0] b4p;
  logic        [32:0] b4e_r;
  logic        [31:0] b7pre_nxt, b7pe_r;
  logic signed [15:0] te_r;
  logic               erre_r;

  // stage F
  logic        [47:0] b7p;
  logic        [31:0] b7;
  bcmp_pkg::ptag_t    pt;
  bcmp_pkg::div_req_t req_r, req_nxt;

  always_comb begin
    tt     = bcmp_pkg::ttag_t'(rsp.tag);
    x2     = $signed({1'b0, rsp.quotient[26:0]});
    x2     = tt.qneg ? -x2 : x2;
    b5     = tt.x1 + x2;
    tsum   = b5 + 30'sd8;
    tq     = tsum[29:4];
    if (tq > 26'sd32767) begin
      tsat = 16'sd32767;
    end else if (tq < -26'sd32768) begin
      tsat = -16'sd32768;
    end else begin
      tsat = tq[15:0];
    end
    b6_nxt = b5 - bcmp_pkg::B6_OFS;
  end

  always_comb begin
    sq_full = b6a_r * b6a_r;
    m2_nxt  = cal.ac2 * b6a_r;
    m3_nxt  = cal.ac3 * b6a_r;
  end

  always_comb begin
    sq12   = sqb_r[54:12];
    pa_nxt = cal.b2 * $signed({1'b0, sqb_r});
    pb_nxt = cal.b1 * $signed({1'b0, sq12});
  end

  // B3 and X3 only matter modulo 2^32 from here on
  always_comb begin
    x1a     = pac_r[71:23];
    x2a     = m2c_r[45:11];
    x3      = x1a + x2a;
    b3s     = (51'(cal.ac1) <<< 2) + x3 + 51'sd2;
    x1b     = m3c_r[45:13];
    x2b     = pbc_r[59:16];
    s2      = x1b + x2b + 45'sd2;
    ulo_nxt = s2[33:2] + bcmp_pkg::X3_OFS;
  end

  always_comb begin
    b4p       = cal.ac4 * uld_r;
    b7pre_nxt = {16'b0, upd_r} - b3d_r;
  end

  // pick the division branch from the top bit of B7
  always_comb begin
    b7p      = b7pe_r * bcmp_pkg::B7_SCALE;
    b7       = b7p[31:0];
    pt.pad   = '0;
    pt.t     = te_r;
    pt.halve = b7[31];
    pt.err   = erre_r | (b4e_r == '0);
    req_nxt.valid    = v_r[4];
    req_nxt.dividend = b7[31] ? bcmp_pkg::div_word_t'(b7) : bcmp_pkg::div_word_t'({b7, 1'b0});
    req_nxt.divisor  = b4e_r;
    req_nxt.tag      = pt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      req_r.valid <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[3:0], rsp.valid};
      req_r.valid <= req_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b6a_r  <= b6_nxt;
      ta_r   <= tsat;
      upa_r  <= tt.up;
      erra_r <= tt.err;

      sqb_r  <= sq_full[54:0];
      m2b_r  <= m2_nxt;
      m3b_r  <= m3_nxt;
      tb_r   <= ta_r;
      upb_r  <= upa_r;
      errb_r <= erra_r;

      pac_r  <= pa_nxt;
      pbc_r  <= pb_nxt;
      m2c_r  <= m2b_r;
      m3c_r  <= m3b_r;
      tc_r   <= tb_r;
      upc_r  <= upb_r;
      errc_r <= errb_r;

      b3d_r  <= b3s[33:2];
      uld_r  <= ulo_nxt;
      td_r   <= tc_r;
      upd_r  <= upc_r;
      errd_r <= errc_r;

      b4e_r  <= b4p[47:15];
      b7pe_r <= b7pre_nxt;
      te_r   <= td_r;
      erre_r <= errd_r;

      req_r.dividend <= req_nxt.dividend;
      req_r.divisor  <= req_nxt.divisor;
      req_r.tag      <= req_nxt.tag;
    end
  end

  assign req = req_r;

endmodule

@@ rtl/core/bcmp_pfinal.sv @@
// ----------------------------------------------------------------------------
// bcmp_pfinal
// Pressure correction polynomial, saturation and error zeroing.
// ----------------------------------------------------------------------------
module bcmp_pfinal (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  bcmp_pkg::div_rsp_t rsp,
  output bcmp_pkg::res_t     res
);

  logic [1:0] v_r;

  // stage G
  bcmp_pkg::ptag_t    pt;
  logic        [32:0] p_nxt, pg_r, ph_r;
  logic        [24:0] ps;
  logic        [49:0] sq2_nxt, sq2g_r;
  logic signed [47:0] m2_nxt, m2g_r;
  logic signed [15:0] tg_r, th_r;
  logic               errg_r, errh_r;

  // stage H
  logic        [61:0] x1c_nxt, x1h_r;
  logic signed [31:0] x2h_r;

  // stage I
  logic        [45:0] x1d;
  logic signed [47:0] s;
  logic signed [48:0] pn;
  bcmp_pkg::res_t     res_r, res_nxt;

  always_comb begin
    pt      = bcmp_pkg::ptag_t'(rsp.tag);
    p_nxt   = pt.halve ? {rsp.quotient[31:0], 1'b0} : rsp.quotient;
    ps      = p_nxt[32:8];
    sq2_nxt = ps * ps;
    m2_nxt  = bcmp_pkg::P_LIN_COEF * $signed({1'b0, p_nxt});
  end

  always_comb begin
    x1c_nxt = sq2g_r * bcmp_pkg::P_SQ_COEF;
  end

  always_comb begin
    x1d = x1h_r[61:16];
    s   = $signed({1'b0, x1d}) + x2h_r + bcmp_pkg::P_OFS;
    pn  = $signed({1'b0, ph_r}) + $signed(s[47:4]);
    res_nxt.valid = v_r[1];
    if (errh_r) begin
      res_nxt.word.temperature_decicelsius = '0;
      res_nxt.word.pressure_pa             = '0;
    end else begin
      res_nxt.word.temperature_decicelsius = th_r;
      if (pn < 49'sd0) begin
        res_nxt.word.pressure_pa = '0;
      end else if (pn > 49'sd1048575) begin
        res_nxt.word.pressure_pa = '1;
      end else begin
        res_nxt.word.pressure_pa = pn[19:0];
      end
    end
    res_nxt.word.divide_error = errh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      res_r.valid <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[0], rsp.valid};
      res_r.valid <= res_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pg_r   <= p_nxt;
      sq2g_r <= sq2_nxt;
      m2g_r  <= m2_nxt;
      tg_r   <= pt.t;
      errg_r <= pt.err;

      x1h_r  <= x1c_nxt;
      x2h_r  <= m2g_r[47:16];
      ph_r   <= pg_r;
      th_r   <= tg_r;
      errh_r <= errg_r;

      res_r.word <= res_nxt.word;
    end
  end

  assign res = res_r;

endmodule

@@ test/barometer_compensation_check.sv @@
// ----------------------------------------------------------------------------
// barometer_compensation_check
// Watches the calibration port and both word channels, predicts each result
// from its own calibration copy and compares it field by field in order.
// ----------------------------------------------------------------------------
module barometer_compensation_check (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  bcmp_pkg::in_word_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  bcmp_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [bcmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcmp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count
);

  logic [63:0]         cal_a, cal_b;
  logic [31:0]         cal_c;
  bcmp_pkg::out_word_t expected_words[$];

  function automatic bcmp_pkg::out_word_t compensate(bcmp_pkg::in_word_t w);
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint ut, up, x1, x2, x3, b3, b5, b6, sq, t, p;
    logic signed [127:0] wide_c, wide_q, prod;
    logic [31:0] x3u, b7;
    longint unsigned b4, pu;
    bcmp_pkg::out_word_t r;
    ac1 = $signed(cal_a[63:48]); ac2 = $signed(cal_a[47:32]);
    ac3 = $signed(cal_a[31:16]); ac4 = cal_a[15:0];
    ac5 = cal_b[63:48]; ac6 = cal_b[47:32];
    b1 = $signed(cal_b[31:16]); b2 = $signed(cal_b[15:0]);
    mc = $signed(cal_c[31:16]); md = $signed(cal_c[15:0]);
    ut = w.raw_temperature;
    up = w.raw_pressure;
    r = '0;
    r.divide_error = 1'b1;
    x1 = ((ut - ac6) * ac5) >>> 15;
    if (x1 + md == 0) return r;
    x2 = (mc * 2048) / (x1 + md);
    b5 = x1 + x2;
    t = (b5 + 8) >>> 4;
    b6 = b5 - 4000;
    sq = b6 * b6;
    // b2 * sq can exceed 64 bits; carry it wide
    wide_c = b2;
    wide_q = sq;
    prod = wide_c * wide_q;
    x1 = longint'(prod >>> 23);
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = (ac1 * 4 + x3 + 2) >>> 2;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * (sq >>> 12)) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    x3u = 32'(x3 + 32768);
    b4 = (longint'(ac4) * longint'({32'b0, x3u})) >> 15;
    if (b4 == 0) return r;
    // B7 wraps modulo 2^32
    b7 = (32'(up) - 32'(b3)) * 32'd50000;
    if (b7 < 32'h8000_0000) pu = ({32'b0, b7} * 2) / b4;
    else pu = ({32'b0, b7} / b4) * 2;
    p = longint'(pu);
    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * 3038) >>> 16;
    x2 = (-7357 * p) >>> 16;
    p = p + ((x1 + x2 + 3791) >>> 4);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    if (p < 0) p = 0;
    if (p > 1048575) p = 1048575;
    r.temperature_decicelsius = 16'(t);
    r.pressure_pa = 20'(p);
    r.divide_error = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    bcmp_pkg::out_word_t exp_w;
    if (!rst_n) begin
      cal_a <= '0;
      cal_b <= '0;
      cal_c <= '0;
      fail_count <= 0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bcmp_pkg::CFG_CAL_A: cal_a <= cfg_data;
          bcmp_pkg::CFG_CAL_B: cal_b <= cfg_data;
          bcmp_pkg::CFG_CAL_C: cal_c <= cfg_data[bcmp_pkg::CAL_C_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_words.push_back(compensate(in_data));
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("unexpected word %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w !== out_data) begin
            if (fail_count < 10)
              $display("mismatch: expected T=%0d P=%0d err=%b, got T=%0d P=%0d err=%b",
                       exp_w.temperature_decicelsius, exp_w.pressure_pa,
                       exp_w.divide_error, out_data.temperature_decicelsius,
                       out_data.pressure_pa, out_data.divide_error);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  // Words still expected; the top reads this after draining
  function automatic int pending();
    return expected_words.size();
  endfunction
endmodule

@@ test/barometer_compensation_test.sv @@
// ----------------------------------------------------------------------------
// barometer_compensation_test
// Drives calibration sets and raw reading words into the compensation block
// with random gaps on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module barometer_compensation_test;

  localparam int LATENCY   = 78;
  localparam int CYCLE_CAP = 1000000;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  bcmp_pkg::in_word_t              in_data;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  bcmp_pkg::out_word_t             out_data;
  logic                            cfg_we;
  logic [bcmp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bcmp_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              fail_count;
  int                              words_sent = 0;
  int                              words_back = 0;
  int                              cycles = 0;
  int                              ready_hold = 0;

  barometer_compensation dut (.*);

  barometer_compensation_check checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count handshakes so the stimulus knows when the pipeline has drained,
  // and stop a hung run at the cycle cap.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_valid && in_ready) words_sent <= words_sent + 1;
    if (rst_n && out_valid && out_ready) words_back <= words_back + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: stall in random bursts, mostly short, now and then long,
  // and run stretches with ready held high.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          out_ready <= 1'b0;
          ready_hold <= $urandom_range(0, 3);
        end
        3: begin
          out_ready <= 1'b0;
          ready_hold <= $urandom_range(10, 40);
        end
        4: begin
          out_ready <= 1'b1;
          ready_hold <= $urandom_range(20, 60);
        end
        default: begin
          out_ready <= 1'b1;
          ready_hold <= 0;
        end
      endcase
    end
  end

  // Hold the word until the block takes it, then leave a random gap.
  // Called at a falling edge; returns at a falling edge.
  task automatic send_word(input bcmp_pkg::in_word_t w);
    int gap;
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    case ($urandom_range(0, 9))
      0, 1, 2: gap = $urandom_range(1, 3);
      3:       gap = $urandom_range(10, 40);
      default: gap = 0;
    endcase
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drain every expected word, then let the pipeline settle.
  task automatic drain();
    in_valid = 1'b0;
    while (words_back != words_sent) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_cal(input logic [bcmp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] v);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_cal(input logic [63:0] a, input logic [63:0] b, input logic [31:0] c);
    write_cal(bcmp_pkg::CFG_CAL_A, a);
    write_cal(bcmp_pkg::CFG_CAL_B, b);
    write_cal(bcmp_pkg::CFG_CAL_C, {32'b0, c});
  endtask

  function automatic bcmp_pkg::in_word_t reading(input int ut, input int up);
    bcmp_pkg::in_word_t w;
    w.raw_temperature = 16'(ut);
    w.raw_pressure    = 16'(up);
    return w;
  endfunction

  // Typical factory coefficients
  localparam logic [63:0] TYP_A = {16'sd408, -16'sd72, -16'sd14383, 16'd32741};
  localparam logic [63:0] TYP_B = {16'd32757, 16'd23153, 16'sd6190, 16'sd4};
  localparam logic [31:0] TYP_C = {-16'sd8711, 16'sd2868};

  initial begin
    int phase;
    int n;
    logic [63:0] ra, rb;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    rst_n      = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Reset calibration: AC5 and MD are zero, so the temperature divisor is zero
    send_word(reading(27898, 23843));
    send_word(reading(16'hFFFF, 0));

    // Typical coefficients across the field extremes
    drain();
    load_cal(TYP_A, TYP_B, TYP_C);
    send_word(reading(27898, 23843));
    send_word(reading(0, 0));
    send_word(reading(16'hFFFF, 16'hFFFF));
    send_word(reading(0, 16'hFFFF));
    send_word(reading(16'hFFFF, 0));
    send_word(reading(23153, 40000));
    send_word(reading(16'h8000, 16'h7FFF));
    send_word(reading(16'h5555, 16'hAAAA));

    // AC4 zero makes the pressure divisor zero
    drain();
    load_cal({TYP_A[63:16], 16'd0}, TYP_B, TYP_C);
    send_word(reading(27898, 23843));
    send_word(reading(30000, 100));

    // All ones: extreme coefficients, saturation likely
    drain();
    load_cal('1, '1, '1);
    send_word(reading(0, 0));
    send_word(reading(16'hFFFF, 16'hFFFF));
    send_word(reading(12345, 54321));

    // Extreme positive and negative coefficients
    drain();
    load_cal({16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
             {16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF}, {16'h7FFF, 16'h0001});
    send_word(reading(0, 0));
    send_word(reading(16'hFFFF, 16'hFFFF));
    send_word(reading(1000, 60000));

    // Random phases: mostly near-typical calibration with realistic readings,
    // some fully random calibration and readings.
    for (phase = 0; phase < 20; phase++) begin
      drain();
      if (phase % 4 == 3) begin
        ra = {$urandom(), $urandom()};
        rb = {$urandom(), $urandom()};
        load_cal(ra, rb, $urandom());
      end else begin
        load_cal(TYP_A ^ 64'($urandom_range(0, 255)), TYP_B ^ 64'($urandom_range(0, 255)),
                 TYP_C ^ 32'($urandom_range(0, 255)));
      end
      for (n = 0; n < 95; n++) begin
        if ($urandom_range(0, 3) == 0)
          send_word(reading($urandom_range(0, 65535), $urandom_range(0, 65535)));
        else
          send_word(reading($urandom_range(20000, 36000), $urandom_range(15000, 42000)));
      end
    end

    drain();
    if (fail_count == 0 && checker_i.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

@@ barometer_compensation.f @@
rtl/core/bcmp_pkg.sv
rtl/core/bcmp_div.sv
rtl/core/bcmp_tfront.sv
rtl/core/bcmp_pcoef.sv
rtl/core/bcmp_pfinal.sv
rtl/core/barometer_compensation.sv
test/barometer_compensation_check.sv
test/barometer_compensation_test.sv
